@@ design/rcau_pkg.sv @@
// Shared types and codes for the radix complement arithmetic unit.
package rcau_pkg;

  localparam int DIGIT_W = 4;

  typedef logic [DIGIT_W-1:0] digit_t;

  localparam logic [2:0] REQ_CONV = 3'd0;
  localparam logic [2:0] REQ_ADD  = 3'd1;
  localparam logic [2:0] REQ_SUB  = 3'd2;
  localparam logic [2:0] REQ_MUL  = 3'd3;
  localparam logic [2:0] REQ_DIV  = 3'd4;
  localparam logic [2:0] REQ_INC  = 3'd5;

  typedef struct packed {
    digit_t x;
    digit_t y;
    digit_t z;
    digit_t cin;
  } du_in_t;

  typedef struct packed {
    digit_t digit;
    digit_t carry;
  } du_out_t;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_NORMA = 11'b00000000010,
    ST_NORMB = 11'b00000000100,
    ST_DISP  = 11'b00000001000,
    ST_CONV  = 11'b00000010000,
    ST_CNEG  = 11'b00000100000,
    ST_ADD   = 11'b00001000000,
    ST_MUL   = 11'b00010000000,
    ST_MULC  = 11'b00100000000,
    ST_DSHF  = 11'b01000000000,
    ST_DSUB  = 11'b10000000000
  } state_t;

endpackage

@@ design/rcau_digit_unit.sv @@
// Shared digit unit: x + y*z + cin split into a radix digit and a carry.
module rcau_digit_unit #(
  parameter int RADIX = 10
) (
  input  rcau_pkg::du_in_t  du_in,
  output rcau_pkg::du_out_t du_out
);

  logic [7:0] sum;
  logic [3:0] quo;
  logic [7:0] base;

  always_comb begin
    sum = 8'(du_in.x) + 8'(du_in.y) * 8'(du_in.z) + 8'(du_in.cin);
    quo = '0;
    for (int k = 1; k < 16; k++) begin
      if (sum >= 8'(k * RADIX)) begin
        quo = 4'(k);
      end
    end
    base = 8'(quo) * 8'(RADIX);
    du_out.digit = rcau_pkg::digit_t'(sum - base);
    du_out.carry = quo;
  end

endmodule

@@ design/radix_complement_arithmetic_unit_top.sv @@
// Top level: sequencer, digit registers and stream ports of the radix unit.
// Flow: normalize both operands, then add/sub/inc, convert (with a negate pass if
// negative), multiply or divide, then hand the result off.
// One request at a time; the single digit unit sets the cycle count.
// rst clears the sequencer and the output valid; no clearing pass.
module radix_complement_arithmetic_unit_top #(
  parameter int RADIX      = 10,
  parameter int DIGITS     = 16,
  parameter int DIGIT_BITS = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [167:0] s_tdata,  // req_type[2:0], int_value[34:3], operand_a[98:35],
                                 // operand_b[162:99], zero fill
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata   // result_value[63:0], result_high[127:64],
                                 // divide_error[128], zero fill
);

  localparam int AW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int PW = $clog2(2 * DIGITS);
  localparam int CW = $clog2(DIGITS + 1);
  localparam rcau_pkg::digit_t RM1 = rcau_pkg::digit_t'(RADIX - 1);

  rcau_pkg::state_t state;
  logic [2:0]       req;
  logic [31:0]      ival;
  logic [63:0]      ra;
  logic [63:0]      rb;
  logic [31:0]      mag;
  logic             neg;
  logic [4:0]       bitcnt;
  logic [CW-1:0]    j;
  logic [AW-1:0]    i;
  rcau_pkg::digit_t c;
  logic             err;
  rcau_pkg::digit_t a   [DIGITS];
  rcau_pkg::digit_t b   [DIGITS];
  rcau_pkg::digit_t p   [2*DIGITS];
  rcau_pkg::digit_t rem [DIGITS+1];
  rcau_pkg::digit_t tmp [DIGITS];
  logic [63:0]      res_value;
  logic [63:0]      res_high;
  logic             res_err;

  rcau_pkg::du_in_t  du_i;
  rcau_pkg::du_out_t du_o;
  logic [PW-1:0]     p_idx;
  logic [AW-1:0]     a_idx;
  logic [AW-1:0]     b_idx;
  rcau_pkg::digit_t  p_rd;
  rcau_pkg::digit_t  a_rd;
  rcau_pkg::digit_t  b_rd;
  logic [31:0]       mag_init;
  logic              b_zero;
  logic              j_last;
  logic [63:0]       pack_lo;
  logic [63:0]       pack_hi;
  logic              div_bad;
  logic              div_fill;
  logic              div_run;
  logic              handoff;

  rcau_digit_unit #(.RADIX(RADIX)) u_du (
    .du_in  (du_i),
    .du_out (du_o)
  );

  assign s_tready = (state == rcau_pkg::ST_IDLE);
  assign m_tdata  = {7'd0, res_err, res_high, res_value};
  assign j_last   = (j == CW'(DIGITS - 1));
  assign mag_init = ival[31] ? (~ival + 32'd1) : ival;
  assign div_bad  = b_zero || (b[DIGITS-1] == RM1);
  assign div_fill = (req == rcau_pkg::REQ_DIV) && !div_bad && (a[DIGITS-1] == RM1);
  assign div_run  = (req == rcau_pkg::REQ_DIV) && !div_bad && (a[DIGITS-1] != RM1);
  assign handoff  = (state == rcau_pkg::ST_MULC) && (j == CW'(DIGITS)) &&
                    (!m_tvalid || m_tready);

  always_comb begin
    b_zero = 1'b1;
    for (int k = 0; k < DIGITS; k++) begin
      if (b[k] != '0) begin
        b_zero = 1'b0;
      end
    end
    pack_lo = '0;
    pack_hi = '0;
    for (int k = 0; k < DIGITS; k++) begin
      pack_lo[k*DIGIT_BITS +: DIGIT_BITS] = p[k][DIGIT_BITS-1:0];
      pack_hi[k*DIGIT_BITS +: DIGIT_BITS] = p[k+DIGITS][DIGIT_BITS-1:0];
    end
  end

  always_comb begin
    a_idx = j[AW-1:0];
    b_idx = j[AW-1:0];
    p_idx = PW'(j);
    unique case (state)
      rcau_pkg::ST_MUL: begin
        p_idx = PW'(i) + PW'(j);
        b_idx = i;
      end
      rcau_pkg::ST_MULC: p_idx = PW'(i) + PW'(DIGITS);
      rcau_pkg::ST_DSHF: a_idx = i;
      rcau_pkg::ST_DSUB: p_idx = PW'(i);
      default: ;
    endcase
    p_rd = p[p_idx];
    a_rd = a[a_idx];
    b_rd = b[b_idx];
  end

  always_comb begin
    du_i = '0;
    du_i.cin = c;
    unique case (state)
      rcau_pkg::ST_NORMA: du_i.x = rcau_pkg::digit_t'(ra[DIGIT_BITS-1:0]);
      rcau_pkg::ST_NORMB: du_i.x = rcau_pkg::digit_t'(rb[DIGIT_BITS-1:0]);
      rcau_pkg::ST_CONV: begin
        du_i.y = p_rd;
        du_i.z = rcau_pkg::digit_t'(2);
      end
      rcau_pkg::ST_CNEG: du_i.x = RM1 - p_rd;
      rcau_pkg::ST_ADD: begin
        du_i.x = a_rd;
        du_i.z = rcau_pkg::digit_t'(1);
        case (req)
          rcau_pkg::REQ_ADD: du_i.y = b_rd;
          rcau_pkg::REQ_SUB: du_i.y = RM1 - b_rd;
          default:           du_i.y = '0;
        endcase
      end
      rcau_pkg::ST_MUL: begin
        du_i.x = p_rd;
        du_i.y = a_rd;
        du_i.z = b_rd;
      end
      rcau_pkg::ST_DSUB: begin
        du_i.x = rem[j];
        du_i.y = (j == CW'(DIGITS)) ? RM1 : (RM1 - b_rd);
        du_i.z = rcau_pkg::digit_t'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= rcau_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (handoff) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state) inside
        rcau_pkg::ST_IDLE: begin
          if (s_tvalid) begin
            req   <= s_tdata[2:0];
            ival  <= s_tdata[34:3];
            ra    <= s_tdata[98:35];
            rb    <= s_tdata[162:99];
            j     <= '0;
            c     <= '0;
            state <= rcau_pkg::ST_NORMA;
          end
        end
        rcau_pkg::ST_NORMA: begin
          a[j[AW-1:0]] <= du_o.digit;
          ra <= ra >> DIGIT_BITS;
          if (j_last) begin
            j     <= '0;
            c     <= '0;
            state <= rcau_pkg::ST_NORMB;
          end else begin
            j <= j + CW'(1);
            c <= du_o.carry;
          end
        end
        rcau_pkg::ST_NORMB: begin
          b[j[AW-1:0]] <= du_o.digit;
          rb <= rb >> DIGIT_BITS;
          if (j_last) begin
            j     <= '0;
            state <= rcau_pkg::ST_DISP;
          end else begin
            j <= j + CW'(1);
            c <= du_o.carry;
          end
        end
        rcau_pkg::ST_DISP: begin
          for (int k = 0; k < 2 * DIGITS; k++) begin
            p[k] <= (div_fill && k < DIGITS) ? RM1 : '0;
          end
          for (int k = 0; k <= DIGITS; k++) begin
            rem[k] <= '0;
          end
          err <= (req == rcau_pkg::REQ_DIV) && div_bad;
          i   <= div_run ? AW'(DIGITS - 1) : '0;
          case (req) inside
            rcau_pkg::REQ_CONV: begin
              mag    <= mag_init;
              neg    <= ival[31];
              bitcnt <= 5'd31;
              j      <= '0;
              c      <= rcau_pkg::digit_t'(mag_init[31]);
              state  <= rcau_pkg::ST_CONV;
            end
            rcau_pkg::REQ_ADD: begin
              j     <= '0;
              c     <= '0;
              state <= rcau_pkg::ST_ADD;
            end
            rcau_pkg::REQ_SUB, rcau_pkg::REQ_INC: begin
              j     <= '0;
              c     <= rcau_pkg::digit_t'(1);
              state <= rcau_pkg::ST_ADD;
            end
            rcau_pkg::REQ_MUL: begin
              j     <= '0;
              c     <= '0;
              state <= rcau_pkg::ST_MUL;
            end
            rcau_pkg::REQ_DIV: begin
              c <= '0;
              if (div_run) begin
                j     <= '0;
                state <= rcau_pkg::ST_DSHF;
              end else begin
                j     <= CW'(DIGITS);
                state <= rcau_pkg::ST_MULC;
              end
            end
            default: begin
              j     <= CW'(DIGITS);
              c     <= '0;
              state <= rcau_pkg::ST_MULC;
            end
          endcase
        end
        rcau_pkg::ST_CONV: begin
          p[p_idx] <= du_o.digit;
          if (!j_last) begin
            j <= j + CW'(1);
            c <= du_o.carry;
          end else if (bitcnt != 5'd0) begin
            j      <= '0;
            bitcnt <= bitcnt - 5'd1;
            c      <= rcau_pkg::digit_t'(mag[30]);
            mag    <= mag << 1;
          end else if (neg) begin
            j     <= '0;
            c     <= rcau_pkg::digit_t'(1);
            state <= rcau_pkg::ST_CNEG;
          end else begin
            j     <= CW'(DIGITS);
            state <= rcau_pkg::ST_MULC;
          end
        end
        rcau_pkg::ST_CNEG, rcau_pkg::ST_ADD: begin
          p[p_idx] <= du_o.digit;
          c <= du_o.carry;
          if (j_last) begin
            j     <= CW'(DIGITS);
            state <= rcau_pkg::ST_MULC;
          end else begin
            j <= j + CW'(1);
          end
        end
        rcau_pkg::ST_MUL: begin
          p[p_idx] <= du_o.digit;
          c <= du_o.carry;
          if (j_last) begin
            j     <= '0;
            state <= rcau_pkg::ST_MULC;
          end else begin
            j <= j + CW'(1);
          end
        end
        rcau_pkg::ST_MULC: begin
          // j below DIGITS marks a product row carry; otherwise result handoff
          if (j != CW'(DIGITS)) begin
            p[p_idx] <= c;
            c <= '0;
            if (i == AW'(DIGITS - 1)) begin
              j <= CW'(DIGITS);
            end else begin
              j     <= '0;
              i     <= i + AW'(1);
              state <= rcau_pkg::ST_MUL;
            end
          end else if (handoff) begin
            res_value <= pack_lo;
            res_high  <= (req == rcau_pkg::REQ_MUL) ? pack_hi : 64'd0;
            res_err   <= err;
            state     <= rcau_pkg::ST_IDLE;
          end
        end
        rcau_pkg::ST_DSHF: begin
          rem[0] <= a_rd;
          for (int k = 1; k <= DIGITS; k++) begin
            rem[k] <= rem[k-1];
          end
          j     <= '0;
          c     <= rcau_pkg::digit_t'(1);
          state <= rcau_pkg::ST_DSUB;
        end
        rcau_pkg::ST_DSUB: begin
          if (j != CW'(DIGITS)) begin
            tmp[j[AW-1:0]] <= du_o.digit;
            c <= du_o.carry;
            j <= j + CW'(1);
          end else if (du_o.carry != '0) begin
            j <= '0;
            c <= rcau_pkg::digit_t'(1);
            for (int k = 0; k < DIGITS; k++) begin
              rem[k] <= tmp[k];
            end
            rem[DIGITS] <= du_o.digit;
            p[p_idx]    <= p_rd + rcau_pkg::digit_t'(1);
          end else if (i == '0) begin
            j     <= CW'(DIGITS);
            state <= rcau_pkg::ST_MULC;
          end else begin
            j     <= '0;
            i     <= i - AW'(1);
            state <= rcau_pkg::ST_DSHF;
          end
        end
        default: state <= rcau_pkg::ST_IDLE;
      endcase
    end
  end

endmodule
